>>> src/imhq_pkg.sv
// shared types and constants for the indexed min-heap queue
// no dependencies
package imhq_pkg;

  localparam int MaxItems = 1024;
  localparam int AddrW    = $clog2(MaxItems);
  localparam int IdW      = 10;
  localparam int PosW     = 11;
  localparam int WeightW  = 32;

  typedef enum logic [1:0] {
    CmdInsert   = 2'd0,
    CmdDecrease = 2'd1,
    CmdExtract  = 2'd2,
    CmdClear    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StEmpty    = 3'd2,
    StAbsent   = 3'd3,
    StDup      = 3'd4,
    StIncrease = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic [IdW-1:0]     item_id;
    logic [WeightW-1:0] key_weight;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]  popped_item;
    status_e         status;
    logic [PosW-1:0] entry_count;
    logic            is_empty;
  } out_t;

endpackage

>>> src/imhq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module imhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/indexed_min_heap_queue.sv
// indexed binary min-heap: heap slots, per-id position and per-id weight in rams
// depends on imhq_pkg and imhq_ram
// clear and extract on an empty heap go straight to the result; insert/decrease look up
// the stored position, check its slot when it is in range, then sift up level by level;
// extract reads the root and the last entry, then sifts down level by level
// throughput: one item at a time, set by the one-read-per-cycle slot and weight rams
// reset: after reset the position ram is swept to zero, all MaxItems entries, no item taken
module indexed_min_heap_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  imhq_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output imhq_pkg::out_t out_item_o
);
  import imhq_pkg::*;

  localparam logic [4:0] SClr   = 5'd0;
  localparam logic [4:0] SIdle  = 5'd1;
  localparam logic [4:0] SLook  = 5'd2;
  localparam logic [4:0] SChk   = 5'd3;
  localparam logic [4:0] SUpA   = 5'd4;
  localparam logic [4:0] SUpB   = 5'd5;
  localparam logic [4:0] SUpC   = 5'd6;
  localparam logic [4:0] SPlace = 5'd7;
  localparam logic [4:0] SXa    = 5'd8;
  localparam logic [4:0] SXb    = 5'd9;
  localparam logic [4:0] SXc    = 5'd10;
  localparam logic [4:0] SDa    = 5'd11;
  localparam logic [4:0] SDb    = 5'd12;
  localparam logic [4:0] SDc    = 5'd13;
  localparam logic [4:0] SDd    = 5'd14;
  localparam logic [4:0] SDe    = 5'd15;
  localparam logic [4:0] SDone  = 5'd16;

  logic [4:0]         state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  cmd_e               cmd_q, cmd_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [WeightW-1:0] w_q, w_d;
  logic [WeightW-1:0] old_w_q, old_w_d;
  logic [PosW-1:0]    count_q, count_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    posv_q, posv_d;
  logic [PosW-1:0]    n_q, n_d;
  logic [IdW-1:0]     cur_id_q, cur_id_d;
  logic [WeightW-1:0] cur_w_q, cur_w_d;
  logic [IdW-1:0]     par_id_q, par_id_d;
  logic [IdW-1:0]     lid_q, lid_d;
  logic [WeightW-1:0] lw_q, lw_d;
  logic [IdW-1:0]     ch_id_q, ch_id_d;
  logic [WeightW-1:0] ch_w_q, ch_w_d;
  logic [PosW-1:0]    ch_pos_q, ch_pos_d;
  logic [IdW-1:0]     root_q, root_d;
  status_e            stat_q, stat_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               slot_we, pos_we, wt_we;
  logic [AddrW-1:0]   slot_waddr, slot_raddr, pos_waddr, pos_raddr, wt_waddr, wt_raddr;
  logic [IdW-1:0]     slot_wdata, slot_rdata;
  logic [PosW-1:0]    pos_wdata, pos_rdata;
  logic [WeightW-1:0] wt_wdata, wt_rdata;

  logic [PosW-1:0]    pos_m1, parent, parent_m1, count_m1, lookup_p;
  logic [PosW:0]      child;
  logic [PosW:0]      child_m1;
  logic               present, resolve;

  imhq_ram #(.Width(IdW), .Depth(MaxItems)) u_slot_ram (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rdata)
  );

  imhq_ram #(.Width(PosW), .Depth(MaxItems)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .raddr_i(pos_raddr), .rdata_o(pos_rdata)
  );

  imhq_ram #(.Width(WeightW), .Depth(MaxItems)) u_wt_ram (
    .clk_i, .we_i(wt_we), .waddr_i(wt_waddr), .wdata_i(wt_wdata),
    .raddr_i(wt_raddr), .rdata_o(wt_rdata)
  );

  assign pos_m1    = pos_q - PosW'(1);
  assign parent    = pos_q >> 1;
  assign parent_m1 = parent - PosW'(1);
  assign count_m1  = count_q - PosW'(1);
  assign child     = {pos_q, 1'b0};
  assign child_m1  = child - (PosW+1)'(1);
  assign lookup_p  = (state_q == SChk) ? posv_q : pos_rdata;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    w_d         = w_q;
    old_w_d     = old_w_q;
    count_d     = count_q;
    pos_d       = pos_q;
    posv_d      = posv_q;
    n_d         = n_q;
    cur_id_d    = cur_id_q;
    cur_w_d     = cur_w_q;
    par_id_d    = par_id_q;
    lid_d       = lid_q;
    lw_d        = lw_q;
    ch_id_d     = ch_id_q;
    ch_w_d      = ch_w_q;
    ch_pos_d    = ch_pos_q;
    root_d      = root_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    slot_we    = 1'b0;
    slot_waddr = pos_m1[AddrW-1:0];
    slot_wdata = cur_id_q;
    slot_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = cur_id_q;
    pos_wdata  = pos_q;
    pos_raddr  = in_item_i.item_id;
    wt_we      = 1'b0;
    wt_waddr   = id_q;
    wt_wdata   = w_q;
    wt_raddr   = in_item_i.item_id;

    present = 1'b0;
    resolve = 1'b0;

    case (state_q)
      SClr: begin
        pos_we    = 1'b1;
        pos_waddr = clr_q;
        pos_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MaxItems - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_d = in_item_i.command;
          id_d  = in_item_i.item_id;
          w_d   = in_item_i.key_weight;
          stat_d = StOk;
          case (in_item_i.command)
            CmdInsert, CmdDecrease: state_d = SLook;
            CmdExtract: begin
              if (count_q == '0) begin
                stat_d  = StEmpty;
                state_d = SDone;
              end else begin
                state_d = SXa;
              end
            end
            default: begin
              count_d = '0;
              state_d = SDone;
            end
          endcase
        end
      end
      SLook: begin
        // a stored position counts only if that slot still holds this id
        old_w_d    = wt_rdata;
        posv_d     = pos_rdata;
        slot_raddr = pos_m1[AddrW-1:0];
        if (pos_rdata != '0 && pos_rdata <= count_q) begin
          slot_raddr = AddrW'(pos_rdata - PosW'(1));
          state_d    = SChk;
        end else begin
          resolve = 1'b1;
        end
      end
      SChk: begin
        present = (slot_rdata == id_q);
        resolve = 1'b1;
      end
      SUpA: begin
        slot_raddr = parent_m1[AddrW-1:0];
        if (pos_q == PosW'(1)) begin
          state_d = SPlace;
        end else begin
          state_d = SUpB;
        end
      end
      SUpB: begin
        par_id_d = slot_rdata;
        wt_raddr = slot_rdata;
        state_d  = SUpC;
      end
      SUpC: begin
        if (wt_rdata > cur_w_q) begin
          slot_we    = 1'b1;
          slot_wdata = par_id_q;
          pos_we     = 1'b1;
          pos_waddr  = par_id_q;
          pos_d      = parent;
          state_d    = SUpA;
        end else begin
          state_d = SPlace;
        end
      end
      SPlace: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        state_d = SDone;
      end
      SXa: begin
        root_d     = slot_rdata;
        slot_raddr = count_m1[AddrW-1:0];
        state_d    = SXb;
      end
      SXb: begin
        cur_id_d = slot_rdata;
        wt_raddr = slot_rdata;
        state_d  = SXc;
      end
      SXc: begin
        cur_w_d = wt_rdata;
        n_d     = count_m1;
        count_d = count_m1;
        pos_d   = PosW'(1);
        state_d = SDa;
      end
      SDa: begin
        slot_raddr = child_m1[AddrW-1:0];
        if (child > {1'b0, n_q}) begin
          state_d = SPlace;
        end else begin
          state_d = SDb;
        end
      end
      SDb: begin
        lid_d      = slot_rdata;
        wt_raddr   = slot_rdata;
        slot_raddr = child[AddrW-1:0];
        state_d    = SDc;
      end
      SDc: begin
        lw_d = wt_rdata;
        if (child < {1'b0, n_q}) begin
          ch_id_d  = slot_rdata;
          wt_raddr = slot_rdata;
          state_d  = SDd;
        end else begin
          ch_id_d  = lid_q;
          ch_w_d   = wt_rdata;
          ch_pos_d = child[PosW-1:0];
          state_d  = SDe;
        end
      end
      SDd: begin
        // right child wins only when the left one is strictly heavier
        if (lw_q > wt_rdata) begin
          ch_w_d   = wt_rdata;
          ch_pos_d = child[PosW-1:0] + PosW'(1);
        end else begin
          ch_id_d  = lid_q;
          ch_w_d   = lw_q;
          ch_pos_d = child[PosW-1:0];
        end
        state_d = SDe;
      end
      SDe: begin
        if (cur_w_q > ch_w_q) begin
          slot_we    = 1'b1;
          slot_wdata = ch_id_q;
          pos_we     = 1'b1;
          pos_waddr  = ch_id_q;
          pos_d      = ch_pos_q;
          state_d    = SDa;
        end else begin
          state_d = SPlace;
        end
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.popped_item = (cmd_q == CmdExtract && stat_q == StOk) ? root_q : '0;
          out_d.status      = stat_q;
          out_d.entry_count = count_q;
          out_d.is_empty    = (count_q == '0);
          out_valid_d       = 1'b1;
          state_d           = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    if (resolve) begin
      state_d = SDone;
      if (cmd_q == CmdInsert) begin
        if (present) begin
          stat_d = StDup;
        end else if (count_q == PosW'(MaxItems)) begin
          stat_d = StFull;
        end else begin
          wt_we    = 1'b1;
          count_d  = count_q + PosW'(1);
          pos_d    = count_q + PosW'(1);
          cur_id_d = id_q;
          cur_w_d  = w_q;
          state_d  = SUpA;
        end
      end else begin
        if (!present) begin
          stat_d = StAbsent;
        end else if (w_q > old_w_q) begin
          stat_d = StIncrease;
        end else begin
          wt_we    = 1'b1;
          pos_d    = lookup_p;
          cur_id_d = id_q;
          cur_w_d  = w_q;
          state_d  = SUpA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    id_q     <= id_d;
    w_q      <= w_d;
    old_w_q  <= old_w_d;
    pos_q    <= pos_d;
    posv_q   <= posv_d;
    n_q      <= n_d;
    cur_id_q <= cur_id_d;
    cur_w_q  <= cur_w_d;
    par_id_q <= par_id_d;
    lid_q    <= lid_d;
    lw_q     <= lw_d;
    ch_id_q  <= ch_id_d;
    ch_w_q   <= ch_w_d;
    ch_pos_q <= ch_pos_d;
    root_q   <= root_d;
    stat_q   <= stat_d;
    out_q    <= out_d;
  end

endmodule
